/* hdl/pta_pkg.sv */
`default_nettype none

package pta_pkg;

  localparam int unsigned HandleW = 16;
  localparam int unsigned KindW   = 3;
  localparam int unsigned CornerW = 2;
  localparam int unsigned MaxRes  = 6;
  localparam int unsigned CountW  = 3;

  // Primitive kind codes
  localparam logic [KindW-1:0] KindTri    = 3'd0;
  localparam logic [KindW-1:0] KindStrip  = 3'd1;
  localparam logic [KindW-1:0] KindFan    = 3'd2;
  localparam logic [KindW-1:0] KindPoly   = 3'd3;
  localparam logic [KindW-1:0] KindQuads  = 3'd4;
  localparam logic [KindW-1:0] KindQStrip = 3'd5;
  localparam logic [KindW-1:0] KindLines  = 3'd6;
  localparam logic [KindW-1:0] KindLStrip = 3'd7;

  // One queued emission: up to six handles that share a segment flag
  typedef struct packed {
    logic [CountW-1:0]                count;
    logic                             is_segment;
    logic [MaxRes-1:0][HandleW-1:0]   handle;
  } job_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

`default_nettype wire

/* hdl/pta_vert_if.sv */
`default_nettype none

interface pta_vert_if import pta_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [HandleW-1:0] vertex_handle;
  logic [KindW-1:0]   prim_kind;
  logic               end_of_primitive;

  modport source (output valid, output vertex_handle, output prim_kind,
                  output end_of_primitive, input ready);
  modport sink   (input valid, input vertex_handle, input prim_kind,
                  input end_of_primitive, output ready);
endinterface

`default_nettype wire

/* hdl/pta_res_if.sv */
`default_nettype none

interface pta_res_if import pta_pkg::*; ;
  logic               valid;
  logic               ready;
  logic [HandleW-1:0] out_handle;
  logic               is_segment;
  logic [CornerW-1:0] corner;
  logic               last_of_run;

  modport source (output valid, output out_handle, output is_segment,
                  output corner, output last_of_run, input ready);
  modport sink   (input valid, input out_handle, input is_segment,
                  input corner, input last_of_run, output ready);
endinterface

`default_nettype wire

/* hdl/pta_front.sv */
`default_nettype none

module pta_front import pta_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  pta_vert_if.sink     vert_i,
  input  q_stat_t      q_stat_i,
  output logic         push_o,
  output job_t         job_o
);

  logic [HandleW-1:0] h0_q, h1_q, h2_q, first_q, first_d;
  logic [1:0]         gp_q, gp_d;
  logic               par_q, par_d;
  logic [1:0]         seen_q, seen_d;
  logic [2:0]         gsize;
  logic [2:0]         gp_inc;
  logic               accept;
  logic [HandleW-1:0] v;

  assign vert_i.ready = !q_stat_i.full;
  assign accept       = vert_i.valid && vert_i.ready;
  assign v            = vert_i.vertex_handle;
  assign gp_inc       = {1'b0, gp_q} + 3'd1;

  always_comb begin
    job_o.count      = '0;
    job_o.is_segment = 1'b0;
    job_o.handle     = '0;
    gsize            = 3'd0;
    unique case (vert_i.prim_kind)
      KindTri: begin
        gsize = 3'd3;
        if (gp_q == 2'd2) begin
          job_o.count  = 3'd3;
          job_o.handle = {48'd0, v, h2_q, h1_q};
        end
      end
      KindStrip: begin
        if (seen_q >= 2'd2) begin
          job_o.count  = 3'd3;
          job_o.handle = par_q ? {48'd0, v, h1_q, h2_q} : {48'd0, v, h2_q, h1_q};
        end
      end
      KindFan, KindPoly: begin
        if (seen_q >= 2'd2) begin
          job_o.count  = 3'd3;
          job_o.handle = {48'd0, v, h2_q, first_q};
        end
      end
      KindQuads: begin
        gsize = 3'd4;
        if (gp_q == 2'd3) begin
          job_o.count  = 3'd6;
          job_o.handle = {v, h2_q, h0_q, h2_q, h1_q, h0_q};
        end
      end
      KindQStrip: begin
        if (seen_q == 2'd3 && par_q) begin
          job_o.count  = 3'd6;
          job_o.handle = {h2_q, v, h0_q, v, h1_q, h0_q};
        end
      end
      KindLines: begin
        gsize = 3'd2;
        if (gp_q == 2'd1) begin
          job_o.count      = 3'd2;
          job_o.is_segment = 1'b1;
          job_o.handle     = {64'd0, v, h2_q};
        end
      end
      default: begin
        if (seen_q != 2'd0) begin
          job_o.count      = 3'd2;
          job_o.is_segment = 1'b1;
          job_o.handle     = {64'd0, v, h2_q};
        end
      end
    endcase
  end

  assign push_o = accept && (job_o.count != '0);

  always_comb begin
    first_d = (seen_q == 2'd0) ? v : first_q;
    gp_d    = gp_q;
    if (gsize != 3'd0) begin
      gp_d = (gp_inc >= gsize) ? 2'd0 : gp_inc[1:0];
    end
    par_d  = !par_q;
    seen_d = (seen_q == 2'd3) ? seen_q : seen_q + 2'd1;
    if (vert_i.end_of_primitive) begin
      gp_d   = 2'd0;
      par_d  = 1'b0;
      seen_d = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h0_q    <= '0;
      h1_q    <= '0;
      h2_q    <= '0;
      first_q <= '0;
      gp_q    <= '0;
      par_q   <= 1'b0;
      seen_q  <= '0;
    end else if (accept) begin
      h0_q    <= h1_q;
      h1_q    <= h2_q;
      h2_q    <= v;
      first_q <= first_d;
      gp_q    <= gp_d;
      par_q   <= par_d;
      seen_q  <= seen_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/pta_job_fifo.sv */
`default_nettype none

module pta_job_fifo import pta_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  job_t    job_i,
  input  logic    pop_i,
  output job_t    job_o,
  output q_stat_t stat_o
);

  job_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;

  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.valid = (cnt_q != 2'd0);
  assign job_o        = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= !wr_q;
      if (pop_i)  rd_q <= !rd_q;
      unique case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full || pop_i) else $error("job queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> stat_o.valid) else $error("job queue underflow");
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("job queue count out of range");
`endif

endmodule

`default_nettype wire

/* hdl/pta_back.sv */
`default_nettype none

module pta_back import pta_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  q_stat_t  q_stat_i,
  input  job_t     job_i,
  output logic     pop_o,
  pta_res_if.source res_o
);

  logic [CountW-1:0]  idx_q;
  logic               load;
  logic               at_end;
  logic               out_valid_q;
  logic [HandleW-1:0] handle_q;
  logic               seg_q;
  logic [CornerW-1:0] corner_q, corner_d;
  logic               last_q;

  assign load   = q_stat_i.valid && (!out_valid_q || res_o.ready);
  assign at_end = (idx_q == job_i.count - 3'd1);
  assign pop_o  = load && at_end;

  always_comb begin
    corner_d = (idx_q >= 3'd3) ? CornerW'(idx_q - 3'd3) : idx_q[CornerW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q       <= at_end ? '0 : idx_q + 3'd1;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      handle_q <= job_i.handle[idx_q];
      seg_q    <= job_i.is_segment;
      corner_q <= corner_d;
      last_q   <= at_end;
    end
  end

  assign res_o.valid       = out_valid_q;
  assign res_o.out_handle  = handle_q;
  assign res_o.is_segment  = seg_q;
  assign res_o.corner      = corner_q;
  assign res_o.last_of_run = last_q;

`ifndef SYNTHESIS
  a_idx_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !q_stat_i.valid |-> idx_q == '0) else $error("beat index left mid-job");
`endif

endmodule

`default_nettype wire

/* hdl/primitive_to_triangle_assembler_unit.sv */
`default_nettype none
// Primitive assembler: vertex stream in, independent triangle/segment list out.
// vert_i carries one vertex handle per beat with its primitive kind and an
// end-of-primitive mark; res_o carries one emitted handle per beat with its
// segment flag, corner and a last_of_run mark on the final beat for that vertex.
// Both channels are valid/ready; a beat moves when valid and ready are high.
// The front classifies each vertex in the cycle it is taken and pushes a job
// of two, three or six handles into a two-entry queue; vertices that close no
// triangle or segment push nothing. The back drains the queue one handle per
// cycle into an output register while the receiver is ready.
// Throughput: one result beat per cycle while res_o.ready is high; a strip or
// fan vertex gives three beats, a quad or quad-strip closer six, a segment two.
// Vertices that emit nothing are taken every cycle while the queue has room.
// Reset clears held handles, counters, the queue and the output valid flag.
// A stalled receiver holds the output beat; the queue then fills and
// vert_i.ready drops until the back frees an entry.
module primitive_to_triangle_assembler_unit import pta_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  pta_vert_if.sink  vert_i,
  pta_res_if.source res_o
);

  logic    push;
  logic    pop;
  job_t    push_job;
  job_t    head_job;
  q_stat_t q_stat;

  // Classify vertices and build jobs
  pta_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vert_i   (vert_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .job_o    (push_job)
  );

  // Decouple the two sides
  pta_job_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .pop_i  (pop),
    .job_o  (head_job),
    .stat_o (q_stat)
  );

  // Serialize each job into result beats
  pta_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .job_i    (head_job),
    .pop_o    (pop),
    .res_o    (res_o)
  );

endmodule

`default_nettype wire
